FILE: rtl/core/spectrum_frame_assembler_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the spectrum frame assembler RTL.
// ---------------------------------------------------------------------------
`ifndef SPECTRUM_FRAME_ASSEMBLER_CORE_ASSERT_SVH
`define SPECTRUM_FRAME_ASSEMBLER_CORE_ASSERT_SVH

// Overlapping implication, checked out of reset.
`define SFA_ASSERT_NOW(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFA_ASSERT_NXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/core/sfa_pkg.sv
// ---------------------------------------------------------------------------
// sfa_pkg
// Types and fixed constants of the spectrum frame assembler.
// ---------------------------------------------------------------------------
package sfa_pkg;

   localparam int BYTES       = 8;
   localparam int BANKS       = 4;
   localparam int WORD_W      = 16;
   localparam int CNT_W       = 11;
   localparam int RIDX_W      = 10;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 24;

   // frame classes
   localparam logic [2:0] CLS_HDR_ACC = 3'd0;
   localparam logic [2:0] CLS_HDR_IGN = 3'd1;
   localparam logic [2:0] CLS_DATA    = 3'd2;
   localparam logic [2:0] CLS_DROP    = 3'd3;
   localparam logic [2:0] CLS_READ    = 3'd4;

   // register indexes
   localparam logic CSR_SIZE_IS_128 = 1'b0;
   localparam logic CSR_INIT_PHASE  = 1'b1;

   localparam logic [7:0]  HDR_TAG     = 8'h07;
   localparam logic [7:0]  HDR_ZERO    = 8'h00;
   localparam logic [15:0] HDR_TIME    = 16'h0001;
   localparam logic [7:0]  ANN_TAG     = 8'h00;
   localparam logic [7:0]  ANN_MAX     = 8'hFF;
   localparam logic [5:0]  BLANK_LARGE = 6'd48;
   localparam logic [5:0]  BLANK_SMALL = 6'd6;
   localparam int          SIZE_LARGE_NOM = 1024;
   localparam int          SIZE_SMALL_NOM = 128;

   typedef struct packed {
      logic frame;   // link frame for this lane
      logic rd;      // read for this lane
      logic hdr;     // header signature seen
      logic hdr_ok;  // header time and length match
      logic rd_ok;   // read index inside size and past blanking
   } sfa_cmd_type;

   typedef struct packed {
      logic [2:0] cls;
      logic       done;
      logic       cbuf;
   } sfa_lane_rsp_type;

   typedef struct packed {
      logic [2:0] cls;
      logic       done;
      logic       cbuf;
      logic       ann;
   } sfa_rsp_type;

endpackage

FILE: rtl/core/spectrum_frame_assembler_core.sv
// ---------------------------------------------------------------------------
// spectrum_frame_assembler_core
// Four-lane spectrum assembler for link frames, with completed-spectrum reads.
// ---------------------------------------------------------------------------
// One word is taken per clock while req_tready is high. Its result is registered
// first by the per-channel bank RAM read and then by the output register. Each
// channel lane owns its counter, ping-pong select and four RAM banks (one per
// 16-bit word of a frame, 2 x MAX_SPECTRUM_WORDS / 4 rounded up to a power of two
// deep each), so a frame writes all four words in the same cycle. The store has no
// clearing pass; reads are only defined for words written since reset. Stalls on
// the result side hold the pipeline; one waiting result never blocks acceptance.
// ---------------------------------------------------------------------------
module spectrum_frame_assembler_core import sfa_pkg::*; #(
   parameter int NUM_CHANNELS       = 4,
   parameter int MAX_SPECTRUM_WORDS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // channel, byte0..byte7, read_index
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind
   input  logic [0:0]             req_tuser,
   // buffer_complete, completed_buffer, all_announced, read_word
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // frame_class
   output logic [2:0]             rsp_tuser,
   input  logic                   csr_wen,
   input  logic                   csr_index,
   input  logic                   csr_wdata
);

   localparam int SIZE_LARGE =
      (SIZE_LARGE_NOM < MAX_SPECTRUM_WORDS) ? SIZE_LARGE_NOM : MAX_SPECTRUM_WORDS;
   localparam int SIZE_SMALL =
      (SIZE_SMALL_NOM < MAX_SPECTRUM_WORDS) ? SIZE_SMALL_NOM : MAX_SPECTRUM_WORDS;

   logic                    size_is_128_ff;
   logic                    init_phase_ff;
   logic [7:0]              ann_cnt_ff, ann_cnt_in;

   logic                    acc;
   logic                    req_kind;
   logic [1:0]              req_channel;
   logic [BYTES-1:0][7:0]   frame_bytes;
   logic [RIDX_W-1:0]       read_index;
   logic [CNT_W-1:0]        size;
   logic [5:0]              blank;
   logic                    ch_ok, hdr, hdr_ok, rd_ok, ann_evt;
   sfa_rsp_type             s0_rsp, out_rsp;
   sfa_lane_rsp_type        lane_rsp [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0][WORD_W-1:0] lane_words;
   logic [WORD_W-1:0]       out_word;

   assign req_kind    = req_tuser[0];
   assign req_channel = req_tdata[1:0];
   assign frame_bytes = req_tdata[65:2];
   assign read_index  = req_tdata[75:66];
   assign acc         = req_tvalid && req_tready;

   assign size  = size_is_128_ff ? CNT_W'(SIZE_SMALL) : CNT_W'(SIZE_LARGE);
   assign blank = size_is_128_ff ? BLANK_SMALL : BLANK_LARGE;
   assign ch_ok = 32'(req_channel) < NUM_CHANNELS;

   assign hdr    = frame_bytes[0] == HDR_TAG && frame_bytes[2] == HDR_ZERO
                   && frame_bytes[7] == HDR_ZERO;
   assign hdr_ok = {frame_bytes[6], frame_bytes[5]} == 16'(size)
                   && {frame_bytes[4], frame_bytes[3]} == HDR_TIME;
   assign rd_ok  = (CNT_W'(read_index) < size) && (read_index >= RIDX_W'(blank));

   // logical-number announcements, counted once per frame, saturating
   assign ann_evt = !req_kind && ch_ok && init_phase_ff && frame_bytes[0] == ANN_TAG
                    && frame_bytes[1] == 8'(req_channel) + 8'd1
                    && ann_cnt_ff != ANN_MAX;
   assign ann_cnt_in = ann_cnt_ff + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_is_128_ff <= 1'b0;
         init_phase_ff  <= 1'b0;
         ann_cnt_ff     <= '0;
      end else begin
         if (csr_wen) begin
            unique case (csr_index)
               CSR_SIZE_IS_128: size_is_128_ff <= csr_wdata;
               CSR_INIT_PHASE:  init_phase_ff  <= csr_wdata;
               default:         size_is_128_ff <= size_is_128_ff;
            endcase
         end
         if (acc && ann_evt) begin
            ann_cnt_ff <= ann_cnt_in;
         end
      end
   end

   for (genvar l = 0; l < NUM_CHANNELS; l++) begin : g_lane
      sfa_cmd_type cmd;
      logic        hit;
      assign hit        = 32'(req_channel) == l;
      assign cmd.frame  = !req_kind && hit;
      assign cmd.rd     = req_kind && hit;
      assign cmd.hdr    = hdr;
      assign cmd.hdr_ok = hdr_ok;
      assign cmd.rd_ok  = rd_ok;

      sfa_lane #(
         .MAX_WORDS (MAX_SPECTRUM_WORDS)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .acc         (acc),
         .cmd         (cmd),
         .size        (size),
         .read_index  (read_index),
         .frame_bytes (frame_bytes),
         .lane_rsp    (lane_rsp[l]),
         .rd_word     (lane_words[l])
      );
   end

   always_comb begin
      s0_rsp     = '0;
      s0_rsp.ann = ann_evt && (ann_cnt_in == 8'(NUM_CHANNELS));
      for (int l = 0; l < NUM_CHANNELS; l++) begin
         s0_rsp.cls  = s0_rsp.cls  | lane_rsp[l].cls;
         s0_rsp.done = s0_rsp.done | lane_rsp[l].done;
         s0_rsp.cbuf = s0_rsp.cbuf | lane_rsp[l].cbuf;
      end
      if (req_kind) begin
         s0_rsp.cls = CLS_READ;
      end else if (!ch_ok) begin
         s0_rsp.cls = CLS_HDR_IGN;
      end
   end

   sfa_merge #(
      .NUM_LANES (NUM_CHANNELS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .acc        (acc),
      .s0_rsp     (s0_rsp),
      .lane_words (lane_words),
      .req_ready  (req_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_item   (out_rsp),
      .rsp_word   (out_word)
   );

   assign rsp_tdata = {5'b0, out_word, out_rsp.ann, out_rsp.cbuf, out_rsp.done};
   assign rsp_tuser = out_rsp.cls;

endmodule

FILE: rtl/core/sfa_ram.sv
// ---------------------------------------------------------------------------
// sfa_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module sfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/sfa_lane.sv
// ---------------------------------------------------------------------------
// sfa_lane
// One channel: word counter, ping-pong select and four-bank spectrum store.
// ---------------------------------------------------------------------------
`include "spectrum_frame_assembler_core_assert.svh"

module sfa_lane import sfa_pkg::*; #(
   parameter int MAX_WORDS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       acc,
   input  sfa_cmd_type                cmd,
   input  logic [CNT_W-1:0]           size,
   input  logic [RIDX_W-1:0]          read_index,
   input  logic [BYTES-1:0][7:0]      frame_bytes,
   output sfa_lane_rsp_type           lane_rsp,
   output logic [WORD_W-1:0]          rd_word
);

   localparam int QDEPTH    = (MAX_WORDS + BANKS - 1) / BANKS;
   localparam int QW        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int IW        = QW + 2;
   localparam int RAM_DEPTH = 2 * (2 ** QW);

   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_inc;
   logic             act_ff, act_in;
   logic             has_ff, has_in;
   logic             rd_hit_ff, rd_hit_in;
   logic [1:0]       bank_ff, bank_in;
   logic             wr_en;
   logic [IW-1:0]    cnt_ext, rd_ext;
   logic [WORD_W-1:0] bank_data [BANKS];

   always_comb begin
      cnt_in   = cnt_ff;
      act_in   = act_ff;
      has_in   = has_ff;
      wr_en    = 1'b0;
      lane_rsp = '0;
      cnt_inc  = cnt_ff + CNT_W'(BANKS);
      if (cmd.frame) begin
         priority if (cmd.hdr) begin
            if (cmd.hdr_ok) begin
               cnt_in       = '0;
               lane_rsp.cls = CLS_HDR_ACC;
            end else begin
               lane_rsp.cls = CLS_HDR_IGN;
            end
         end else if (cnt_ff >= size) begin
            // only reachable after a size change; stuck until a header
            lane_rsp.cls = CLS_DROP;
         end else begin
            wr_en        = 1'b1;
            cnt_in       = cnt_inc;
            lane_rsp.cls = CLS_DATA;
         end
         // a rejected header also flips a counter that sits exactly at size
         if (lane_rsp.cls != CLS_DROP && cnt_in == size) begin
            lane_rsp.done = 1'b1;
            lane_rsp.cbuf = act_ff;
            act_in        = ~act_ff;
            has_in        = 1'b1;
            cnt_in        = '0;
         end
      end
   end

   assign rd_hit_in = cmd.rd && cmd.rd_ok && has_ff;
   assign bank_in   = read_index[1:0];
   assign cnt_ext   = IW'(cnt_ff);
   assign rd_ext    = IW'(read_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         act_ff    <= 1'b0;
         has_ff    <= 1'b0;
         rd_hit_ff <= 1'b0;
         bank_ff   <= '0;
      end else if (acc) begin
         cnt_ff    <= cnt_in;
         act_ff    <= act_in;
         has_ff    <= has_in;
         rd_hit_ff <= rd_hit_in;
         bank_ff   <= bank_in;
      end
   end

   // word i of a frame lands in bank i; the counter is always a multiple of four
   for (genvar i = 0; i < BANKS; i++) begin : g_bank
      logic bank_we;
      assign bank_we = acc && wr_en && ((32'(cnt_ff) + i) < MAX_WORDS);

      sfa_ram #(
         .WIDTH (WORD_W),
         .DEPTH (RAM_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_we),
         .wr_addr ({act_ff, cnt_ext[IW-1:2]}),
         .wr_data ({frame_bytes[2*i+1], frame_bytes[2*i]}),
         .rd_en   (acc && cmd.rd),
         .rd_addr ({~act_ff, rd_ext[IW-1:2]}),
         .rd_data (bank_data[i])
      );
   end

   assign rd_word = rd_hit_ff ? bank_data[bank_ff] : '0;

   `SFA_ASSERT_NXT(a_lane_flip, clock, reset, acc && cmd.frame && lane_rsp.done, act_ff != $past(act_ff) && has_ff && cnt_ff == '0, "buffer did not flip on completion")
   `SFA_ASSERT_NXT(a_lane_drop, clock, reset, acc && cmd.frame && lane_rsp.cls == CLS_DROP, $stable(cnt_ff) && $stable(act_ff), "dropped word changed lane state")
   `SFA_ASSERT_NXT(a_lane_step, clock, reset, acc && lane_rsp.cls == CLS_DATA && !lane_rsp.done, cnt_ff == $past(cnt_ff) + CNT_W'(BANKS), "counter did not advance by one frame")

endmodule

FILE: rtl/core/sfa_merge.sv
// ---------------------------------------------------------------------------
// sfa_merge
// Combines the lanes' read data with the decision and holds the result word.
// ---------------------------------------------------------------------------
`include "spectrum_frame_assembler_core_assert.svh"

module sfa_merge import sfa_pkg::*; #(
   parameter int NUM_LANES = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              acc,
   input  sfa_rsp_type                       s0_rsp,
   input  logic [NUM_LANES-1:0][WORD_W-1:0]  lane_words,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output sfa_rsp_type                       rsp_item,
   output logic [WORD_W-1:0]                 rsp_word
);

   logic              s1_valid_ff, s1_valid_in;
   sfa_rsp_type       s1_rsp_ff;
   logic              o_valid_ff, o_valid_in;
   sfa_rsp_type       o_rsp_ff;
   logic [WORD_W-1:0] o_word_ff;
   logic [WORD_W-1:0] word_or;
   logic              s1_move;

   // idle lanes drive zero
   always_comb begin
      word_or = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
         word_or = word_or | lane_words[l];
      end
   end

   assign s1_move     = s1_valid_ff && (!o_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_move;
   assign s1_valid_in = acc || (s1_valid_ff && !s1_move);
   assign o_valid_in  = s1_move || (o_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         o_valid_ff  <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_rsp_ff <= s0_rsp;
      end
      if (s1_move) begin
         o_rsp_ff  <= s1_rsp_ff;
         o_word_ff <= word_or;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_item  = o_rsp_ff;
   assign rsp_word  = o_word_ff;

   `SFA_ASSERT_NOW(a_mrg_no_overrun, clock, reset, acc, !s1_valid_ff || s1_move, "word accepted over a held stage")
   `SFA_ASSERT_NXT(a_mrg_hold, clock, reset, s1_valid_ff && !s1_move, s1_valid_ff && $stable(s1_rsp_ff), "held word lost")
   `SFA_ASSERT_NXT(a_mrg_word_zero, clock, reset, s1_move && s1_rsp_ff.cls != CLS_READ, o_word_ff == '0, "non-read word carries data")

endmodule
